>>> design/shs_pkg.sv
// Shared types and SHA-256 constants for the byte stream hasher.
package shs_pkg;

    // One queued command: a message byte and/or an end-of-message mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } cmd_t;

    // One digest word as it leaves the hasher.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } result_t;

    localparam int DIGEST_WORDS = 8;
    localparam int ROUNDS       = 64;

    localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // First padding byte after the message.
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Fill position at which the length field begins.
    localparam logic [5:0] LEN_START = 6'd56;

    // Last byte position of a block.
    localparam logic [5:0] LAST_BYTE = 6'd63;

endpackage

>>> design/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: input queue, hash engine, result register.
//
// The hasher takes one message byte per push transaction and returns the eight digest
// words, most significant first, after an item with end_of_message set. Items flow into a
// command queue of QUEUE_DEPTH entries; with a depth above one, full only rises while the
// hash engine is busy. The engine absorbs one byte per cycle; the 64th byte of each block
// starts a compression (64 rounds on one shared round unit, then the chain update), during
// which the queue holds further bytes. An end-of-message item adds padding bytes up to the
// block end and a compression; when fewer than nine bytes of the block are left for the
// 0x80 mark and the length field, a second block of 64 padding bytes and a second
// compression follow. The digest then leaves at one word per cycle while the result side
// pops. Items with neither a byte nor an end mark are taken and dropped.
module sha256_byte_stream_hasher
    import shs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    cmd_t    cmd;
    logic    cmd_avail;
    logic    cmd_take;
    logic    eng_valid;
    logic    eng_ready;
    result_t eng_word;
    result_t res_reg;
    logic    res_full_reg;

    shs_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .cmd_avail      (cmd_avail),
        .cmd            (cmd),
        .cmd_take       (cmd_take)
    );

    shs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (cmd_avail),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .out_valid (eng_valid),
        .out_word  (eng_word),
        .out_ready (eng_ready)
    );

    // Result register: refilled in the same cycle that its word is popped.
    assign eng_ready = !res_full_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_full_reg <= 1'b0;
        end
        else if (eng_valid && eng_ready)
        begin
            res_full_reg <= 1'b1;
        end
        else if (pop)
        begin
            res_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_valid && eng_ready)
        begin
            res_reg <= eng_word;
        end
    end

    assign empty       = !res_full_reg;
    assign digest_word = res_reg.digest_word;
    assign word_index  = res_reg.word_index;
    assign last_word   = res_reg.last_word;

endmodule

>>> design/shs_front.sv
// Front end: accepts input transactions, drops empty ones and queues commands.
module shs_front
    import shs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  logic [7:0] data_byte,
    input  logic byte_valid,
    input  logic end_of_message,
    output logic cmd_avail,
    output cmd_t cmd,
    input  logic cmd_take
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t           queue_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           wr_en;

    assign full      = (count_reg == CW'(DEPTH));
    assign cmd_avail = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    // An item with neither a byte nor an end mark has no effect and is not queued.
    assign wr_en = push && !full && (byte_valid || end_of_message);

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_take)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !cmd_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && cmd_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wr_ptr_reg] <= '{data_byte: data_byte, byte_valid: byte_valid,
                                       end_of_message: end_of_message};
        end
    end

endmodule

>>> design/shs_back.sv
// Back end: block buffer, padding sequencer, 64-round compression and digest readout.
module shs_back
    import shs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_avail,
    input  cmd_t    cmd,
    output logic    cmd_take,
    output logic    out_valid,
    output result_t out_word,
    input  logic    out_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  len_reg, len_next;
    logic         pad_reg, pad_next;
    logic         first_reg, first_next;
    logic         len_ok_reg, len_ok_next;
    logic         fin_reg, fin_next;
    logic [5:0]   round_reg, round_next;
    logic [2:0]   idx_reg, idx_next;
    logic [31:0]  chain_reg [DIGEST_WORDS];
    logic [31:0]  chain_next [DIGEST_WORDS];
    logic [31:0]  v_reg [DIGEST_WORDS];
    logic [31:0]  v_next [DIGEST_WORDS];
    logic [511:0] blk_reg, blk_next;

    logic         load_v;
    logic [63:0]  len_bits;
    logic [7:0]   len_byte;
    logic [7:0]   pad_byte;
    logic [31:0]  t1, t2, w_new;

    function automatic logic [31:0] ror(input logic [31:0] x, input int r);
        ror = (x >> r) | (x << (32 - r));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    // Round datapath: working variables a..h live in v_reg[0..7].
    assign t1 = v_reg[7] + big_s1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[round_reg] + blk_reg[511:480];
    assign t2 = big_s0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // Message schedule: the block buffer shifts one word per round.
    assign w_new = small_s1(blk_reg[63:32]) + blk_reg[223:192]
                 + small_s0(blk_reg[479:448]) + blk_reg[511:480];

    // Length field bytes, most significant first at fill positions 56..63.
    assign len_bits = {len_reg, 3'b000};
    assign len_byte = 8'(len_bits >> {~fill_reg[2:0], 3'b000});
    assign pad_byte = first_reg ? PAD_MARK
                    : ((len_ok_reg && (fill_reg >= LEN_START)) ? len_byte : 8'h00);

    assign cmd_take  = (state_reg == S_IDLE) && cmd_avail;
    assign out_valid = (state_reg == S_OUT);
    assign out_word  = '{digest_word: chain_reg[idx_reg], word_index: idx_reg,
                         last_word: (idx_reg == 3'(DIGEST_WORDS - 1))};

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        pad_next    = pad_reg;
        first_next  = first_reg;
        len_ok_next = len_ok_reg;
        fin_next    = fin_reg;
        round_next  = round_reg;
        idx_next    = idx_reg;
        blk_next    = blk_reg;
        load_v      = 1'b0;
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            chain_next[i] = chain_reg[i];
            v_next[i]     = v_reg[i];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_avail)
                begin
                    if (cmd.byte_valid)
                    begin
                        blk_next  = {blk_reg[503:0], cmd.data_byte};
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 61'd1;
                    end
                    if (cmd.end_of_message)
                    begin
                        pad_next    = 1'b1;
                        first_next  = 1'b1;
                        len_ok_next = 1'b0;
                        fin_next    = 1'b0;
                    end
                    if (cmd.byte_valid && (fill_reg == LAST_BYTE))
                    begin
                        load_v     = 1'b1;
                        state_next = S_COMP;
                    end
                    else if (cmd.end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                blk_next  = {blk_reg[503:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (first_reg)
                begin
                    first_next  = 1'b0;
                    len_ok_next = (fill_reg < LEN_START);
                end
                // A full padded block is compressed; it is final once it holds the length.
                if (fill_reg == LAST_BYTE)
                begin
                    fin_next    = !first_reg && len_ok_reg;
                    len_ok_next = 1'b1;
                    load_v      = 1'b1;
                    state_next  = S_COMP;
                end
            end
            S_COMP:
            begin
                for (int i = 1; i < DIGEST_WORDS; i++)
                begin
                    v_next[i] = v_reg[i-1];
                end
                v_next[0]  = t1 + t2;
                v_next[4]  = v_reg[3] + t1;
                blk_next   = {blk_reg[479:0], w_new};
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                if (fin_reg)
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    // Last word delivered: back to the initial hash value and an empty message.
                    if (idx_reg == 3'(DIGEST_WORDS - 1))
                    begin
                        for (int i = 0; i < DIGEST_WORDS; i++)
                        begin
                            chain_next[i] = INIT_HASH[i];
                        end
                        fill_next  = '0;
                        len_next   = '0;
                        pad_next   = 1'b0;
                        fin_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_v)
        begin
            round_next = '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                v_next[i] = chain_reg[i];
            end
        end
    end

    // Control and chaining state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            pad_reg    <= 1'b0;
            first_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            fin_reg    <= 1'b0;
            round_reg  <= '0;
            idx_reg    <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            pad_reg    <= pad_next;
            first_reg  <= first_next;
            len_ok_reg <= len_ok_next;
            fin_reg    <= fin_next;
            round_reg  <= round_next;
            idx_reg    <= idx_next;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // Block buffer and working variables.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            v_reg[i] <= v_next[i];
        end
    end

    // Padding always ends on a block boundary before the digest is read out.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_reg == '0) && pad_reg)
        else $error("digest readout with a partial block");

    // Compression runs until the chain update.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) |=> (state_reg == S_COMP) || (state_reg == S_ADD))
        else $error("compression left early");

    // A final chain update is followed by the readout of word zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) && fin_reg |=> out_valid && (idx_reg == '0))
        else $error("final block not followed by readout");

    // After the last word the message state is back at its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_word.last_word
        |=> (state_reg == S_IDLE) && (len_reg == '0) && !pad_reg)
        else $error("state not restored after digest");

endmodule
